/* src/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the CORDIC sine/cosine pipeline
// Q4.28 angle constants, arctangent table and the per-stage data record.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int MAX_ITERATIONS = 28;
   localparam int DATA_W         = 32;
   localparam int OUT_W          = 31;
   localparam int ITER_W         = 5;

   localparam logic signed [DATA_W-1:0] Q_PI      = 32'sd843314857;
   localparam logic signed [DATA_W-1:0] Q_TWO_PI  = 32'sd1686629713;
   localparam logic signed [DATA_W-1:0] Q_HALF_PI = 32'sd421657428;
   localparam logic signed [DATA_W-1:0] Q_KINV    = 32'sd163008218;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [ITER_W-1:0]        iter_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      logic     fold;
      iter_type n;
   } csc_data_type;

   // atan(2^-i) in Q4.28, rounded to nearest
   function automatic word_type atan_entry(input iter_type idx);
      word_type a;
      case (idx)
         5'd0:    a = 32'sd210828714;
         5'd1:    a = 32'sd124459457;
         5'd2:    a = 32'sd65760959;
         5'd3:    a = 32'sd33381290;
         5'd4:    a = 32'sd16755422;
         5'd5:    a = 32'sd8385879;
         5'd6:    a = 32'sd4193963;
         5'd7:    a = 32'sd2097109;
         5'd8:    a = 32'sd1048571;
         5'd9:    a = 32'sd524287;
         5'd10:   a = 32'sd262144;
         5'd11:   a = 32'sd131072;
         5'd12:   a = 32'sd65536;
         5'd13:   a = 32'sd32768;
         5'd14:   a = 32'sd16384;
         5'd15:   a = 32'sd8192;
         5'd16:   a = 32'sd4096;
         5'd17:   a = 32'sd2048;
         5'd18:   a = 32'sd1024;
         5'd19:   a = 32'sd512;
         5'd20:   a = 32'sd256;
         5'd21:   a = 32'sd128;
         5'd22:   a = 32'sd64;
         5'd23:   a = 32'sd32;
         5'd24:   a = 32'sd16;
         5'd25:   a = 32'sd8;
         5'd26:   a = 32'sd4;
         5'd27:   a = 32'sd2;
         5'd28:   a = 32'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* src/csc_channels.sv */
// ----------------------------------------------------------------------------
// csc_channels: valid/ready channel interfaces
// Request angle channel, sine/cosine response channel and register write port.
// ----------------------------------------------------------------------------
interface csc_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

interface csc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [30:0] sine;
   logic signed [30:0] cosine;

   modport source (output valid, output sine, output cosine, input ready);
   modport sink   (input valid, input sine, input cosine, output ready);
endinterface

interface csc_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* src/csc_prep.sv */
// ----------------------------------------------------------------------------
// csc_prep: angle range reduction
// Stage 1 wraps into [-pi, pi]; stage 2 folds into [-pi/2, pi/2] and seeds
// the CORDIC vector.
// ----------------------------------------------------------------------------
module csc_prep (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  csc_pkg::word_type     in_angle,
   input  csc_pkg::iter_type     iterations,
   output logic                  out_valid,
   input  logic                  out_ready,
   output csc_pkg::csc_data_type out_data
);
   import csc_pkg::*;

   logic     wrap_valid_ff, wrap_valid_in;
   word_type wrap_t_ff, wrap_t_in;
   iter_type wrap_n_ff, wrap_n_in;
   logic     wrap_ready;

   logic         fold_valid_ff, fold_valid_in;
   csc_data_type fold_data_ff, fold_data_in;
   logic         fold_ready;

   // stage 1: wrap, saturate the iteration count
   assign wrap_ready = !wrap_valid_ff || fold_ready;
   assign in_ready   = wrap_ready;

   always_comb begin
      wrap_t_in = in_angle;
      if (!(Q_PI > in_angle)) begin
         wrap_t_in = in_angle - Q_TWO_PI;
      end else if (!(in_angle > -Q_PI)) begin
         wrap_t_in = in_angle + Q_TWO_PI;
      end
      wrap_n_in = (iterations > iter_type'(MAX_ITERATIONS))
                  ? iter_type'(MAX_ITERATIONS) : iterations;
      wrap_valid_in = wrap_ready ? in_valid : wrap_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
      end else begin
         wrap_valid_ff <= wrap_valid_in;
      end
      if (in_valid && wrap_ready) begin
         wrap_t_ff <= wrap_t_in;
         wrap_n_ff <= wrap_n_in;
      end
   end

   // stage 2: fold by pi
   assign fold_ready = !fold_valid_ff || out_ready;

   always_comb begin
      fold_data_in.x    = Q_KINV;
      fold_data_in.y    = '0;
      fold_data_in.z    = wrap_t_ff;
      fold_data_in.fold = 1'b0;
      fold_data_in.n    = wrap_n_ff;
      if (wrap_t_ff > Q_HALF_PI) begin
         fold_data_in.z    = wrap_t_ff - Q_PI;
         fold_data_in.fold = 1'b1;
      end else if (-Q_HALF_PI > wrap_t_ff) begin
         fold_data_in.z    = wrap_t_ff + Q_PI;
         fold_data_in.fold = 1'b1;
      end
      fold_valid_in = fold_ready ? wrap_valid_ff : fold_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= fold_valid_in;
      end
      if (wrap_valid_ff && fold_ready) begin
         fold_data_ff <= fold_data_in;
      end
   end

   assign out_valid = fold_valid_ff;
   assign out_data  = fold_data_ff;

endmodule

/* src/csc_stage.sv */
// ----------------------------------------------------------------------------
// csc_stage: one CORDIC micro-rotation with its pipeline register
// The stage index picks shift and arctangent; stages past the item's count
// pass the vector unchanged.
// ----------------------------------------------------------------------------
module csc_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  csc_pkg::iter_type     stage_idx,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  csc_pkg::csc_data_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output csc_pkg::csc_data_type out_data
);
   import csc_pkg::*;

   logic         valid_ff, valid_in;
   csc_data_type data_ff, data_in;
   word_type     xs, ys, a;
   logic         active;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs     = in_data.x >>> stage_idx;
      ys     = in_data.y >>> stage_idx;
      a      = atan_entry(stage_idx);
      active = stage_idx < in_data.n;
      data_in = in_data;
      if (active) begin
         if (!in_data.z[DATA_W-1]) begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - a;
         end else begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + a;
         end
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/cordic_sine_cosine_top.sv */
// Stages: 2 reduction stages, 28 CORDIC stages and 1 output stage; the CORDIC
// stages are the unrolled micro-rotation pipeline.
// Throughput: one request per cycle unless stalled; each stage holds under
// backpressure and bubbles collapse: requests enter until every stage is full.
// Reset (synchronous): pipeline emptied, iterations register set to 16.
// ----------------------------------------------------------------------------
// cordic_sine_cosine_top: pipelined CORDIC sine/cosine, Q4.28 angle, Q3.28 out
// Range reduction, unrolled rotation stages and a final sign-restore stage.
// ----------------------------------------------------------------------------
module cordic_sine_cosine_top (
   input  logic clock,
   input  logic reset,
   csc_req_if.sink   req_chan,
   csc_rsp_if.source rsp_chan,
   csc_csr_if.sink   csr_chan
);
   import csc_pkg::*;

   localparam iter_type ITER_RESET = 5'd16;

   iter_type iterations_ff, iterations_in;

   assign csr_chan.ready = 1'b1;
   assign iterations_in  = csr_chan.valid ? csr_chan.data : iterations_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iterations_ff <= ITER_RESET;
      end else begin
         iterations_ff <= iterations_in;
      end
   end

   logic         chain_valid [0:MAX_ITERATIONS];
   logic         chain_ready [0:MAX_ITERATIONS];
   csc_data_type chain_data  [0:MAX_ITERATIONS];

   csc_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_angle   (req_chan.angle),
      .iterations (iterations_ff),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_data   (chain_data[0])
   );

   for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_rot
      csc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (iter_type'(g)),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // output stage: undo the fold by negating both components
   logic                    out_valid_ff, out_valid_in;
   logic signed [OUT_W-1:0] sine_ff, sine_in, cosine_ff, cosine_in;
   word_type                x_fin, y_fin;
   logic                    out_ready;

   assign out_ready = !out_valid_ff || rsp_chan.ready;
   assign chain_ready[MAX_ITERATIONS] = out_ready;

   always_comb begin
      x_fin = chain_data[MAX_ITERATIONS].x;
      y_fin = chain_data[MAX_ITERATIONS].y;
      if (chain_data[MAX_ITERATIONS].fold) begin
         x_fin = -chain_data[MAX_ITERATIONS].x;
         y_fin = -chain_data[MAX_ITERATIONS].y;
      end
      sine_in      = y_fin[OUT_W-1:0];
      cosine_in    = x_fin[OUT_W-1:0];
      out_valid_in = out_ready ? chain_valid[MAX_ITERATIONS] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (chain_valid[MAX_ITERATIONS] && out_ready) begin
         sine_ff   <= sine_in;
         cosine_ff <= cosine_in;
      end
   end

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.sine   = sine_ff;
   assign rsp_chan.cosine = cosine_ff;

endmodule

/* bench/tb_cordic_sine_cosine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cordic_sine_cosine_top: self-checking bench for the CORDIC sine/cosine
// Drives angles through the request channel with random gaps and response
// stalls. Each accepted request is scored against a bit-exact rotation
// predictor, and the iteration count is swept between the request bursts.
// ----------------------------------------------------------------------------
module tb_cordic_sine_cosine_top;
   import csc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [31:0] angle;
      logic [4:0]  iters;
      logic [30:0] sine;
      logic [30:0] cosine;
   } sincos_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   csc_req_if req_if ();
   csc_rsp_if rsp_if ();
   csc_csr_if csr_if ();

   cordic_sine_cosine_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // atan(2^-i) in Q4.28
   logic [31:0] atan_q28 [0:28] = '{
      32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290,
      32'd16755422,  32'd8385879,   32'd4193963,  32'd2097109,
      32'd1048571,   32'd524287,    32'd262144,   32'd131072,
      32'd65536,     32'd32768,     32'd16384,    32'd8192,
      32'd4096,      32'd2048,      32'd1024,     32'd512,
      32'd256,       32'd128,       32'd64,       32'd32,
      32'd16,        32'd8,         32'd4,        32'd2,
      32'd1
   };

   sincos_rec_type sincos_expected [$];
   logic [4:0]  iterations_shadow;
   logic        req_idle_en = 1'b1;
   logic        rsp_idle_en = 1'b1;
   int          cycle_count = 0;
   int          error_count = 0;
   int          angles_sent = 0;
   int          responses_checked = 0;
   int          settings_used = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, sincos_expected.size());
         $display("cordic_sine_cosine_top verification failed");
         $finish;
      end
   end

   function automatic void cordic_sincos(input logic signed [31:0] angle,
                                         input logic [4:0] iters,
                                         output logic [30:0] sine,
                                         output logic [30:0] cosine);
      logic signed [31:0] t, x, y, z, xs, ys;
      logic folded;
      int n;
      t = angle;
      folded = 1'b0;
      // single wrap into [-pi, pi]
      if (!(Q_PI > t)) t = t - Q_TWO_PI;
      else if (!(t > -Q_PI)) t = t + Q_TWO_PI;
      // single fold into [-pi/2, pi/2]; result is negated later
      if (t > Q_HALF_PI) begin
         t = t - Q_PI;
         folded = 1'b1;
      end else if (-Q_HALF_PI > t) begin
         t = t + Q_PI;
         folded = 1'b1;
      end
      n = (iters > MAX_ITERATIONS) ? MAX_ITERATIONS : int'(iters);
      x = Q_KINV;
      y = '0;
      z = t;
      for (int i = 0; i < n; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (!z[31]) begin
            x = x - ys;
            y = y + xs;
            z = z - $signed(atan_q28[i]);
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + $signed(atan_q28[i]);
         end
      end
      if (folded) begin
         x = -x;
         y = -y;
      end
      sine = y[30:0];
      cosine = x[30:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] angle,
                                  input logic [4:0] iters,
                                  input logic [31:0] got, input logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("[%0t] MISMATCH %s: angle=%0d iters=%0d got=%0d want=%0d",
                  $realtime, what, $signed(angle), iters,
                  $signed(got), $signed(want));
   endtask

   // request monitor, register shadow and response scoreboard
   always @(posedge clock) begin : scoreboard
      sincos_rec_type rec;
      if (reset) begin
         iterations_shadow <= 5'd16;
      end else begin
         if (csr_if.valid && csr_if.ready) iterations_shadow <= csr_if.data;
         if (req_if.valid && req_if.ready) begin
            rec.angle = req_if.angle;
            rec.iters = iterations_shadow;
            cordic_sincos(req_if.angle, iterations_shadow, rec.sine, rec.cosine);
            sincos_expected.push_back(rec);
            angles_sent++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (sincos_expected.size() == 0) begin
               report_mismatch("unexpected response", 32'd0, iterations_shadow,
                               {{1{rsp_if.sine[30]}}, rsp_if.sine}, 32'd0);
            end else begin
               rec = sincos_expected.pop_front();
               responses_checked++;
               if (rsp_if.sine !== rec.sine)
                  report_mismatch("sine", rec.angle, rec.iters,
                                  {{1{rsp_if.sine[30]}}, rsp_if.sine},
                                  {{1{rec.sine[30]}}, rec.sine});
               if (rsp_if.cosine !== rec.cosine)
                  report_mismatch("cosine", rec.angle, rec.iters,
                                  {{1{rsp_if.cosine[30]}}, rsp_if.cosine},
                                  {{1{rec.cosine[30]}}, rec.cosine});
            end
         end
      end
   end

   // response side: random stall before each response while stalls are enabled
   initial begin : response_sink
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_idle_en ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // valid is left high after a request so back-to-back requests stay seamless
   task automatic send_angle(input logic [31:0] angle);
      int gap;
      gap = req_idle_en ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.angle <= angle;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // lets the scoreboard queue the last accepted request, then waits for an empty queue
   task automatic drain_responses();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sincos_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_iterations(input logic [4:0] value);
      drain_responses();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [31:0] pick_angle();
      logic signed [31:0] base;
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
         // uniform over the nominal -2pi..2pi range
         return $urandom_range(0, 32'd3373259426) - Q_TWO_PI;
      end else if (sel <= 7) begin
         case ($urandom_range(0, 6))
            0:       base = Q_PI;
            1:       base = -Q_PI;
            2:       base = Q_HALF_PI;
            3:       base = -Q_HALF_PI;
            4:       base = Q_TWO_PI;
            5:       base = -Q_TWO_PI;
            default: base = '0;
         endcase
         return base + $signed($urandom_range(0, 64)) - 32;
      end
      return $urandom();
   endfunction

   // runs on the reset value of the iteration count
   task automatic test_angle_extremes();
      send_angle(32'd0);
      send_angle(32'd1);
      send_angle(-32'sd1);
      send_angle(Q_HALF_PI);
      send_angle(Q_HALF_PI + 1);
      send_angle(-Q_HALF_PI);
      send_angle(-Q_HALF_PI - 1);
      send_angle(Q_PI - 1);
      send_angle(Q_PI);
      send_angle(-Q_PI);
      send_angle(-Q_PI + 1);
      send_angle(Q_TWO_PI);
      send_angle(-Q_TWO_PI);
      send_angle(32'h7FFF_FFFF);
      send_angle(32'h8000_0000);
      send_angle(32'h4000_0000);
      send_angle(32'hC000_0000);
      drain_responses();
   endtask

   // zero rotations, the full table and counts past it
   task automatic test_iteration_limits();
      write_iterations(5'd0);
      send_angle(32'd0);
      send_angle(32'sd268435456);
      send_angle(32'sd671088640);
      send_angle(-32'sd671088640);
      write_iterations(5'd28);
      send_angle(32'sd100000000);
      send_angle(-32'sd900000000);
      write_iterations(5'd31);
      send_angle(32'sd100000000);
      send_angle(-32'sd900000000);
      send_angle(Q_PI);
      drain_responses();
   endtask

   task automatic test_random_sweep();
      logic [4:0] setting;
      logic [1:0] mode;
      for (int p = 0; p < 12; p++) begin
         case (p)
            0:       setting = 5'd28;
            1:       setting = 5'd0;
            2:       setting = 5'd31;
            3:       setting = 5'd1;
            4:       setting = 5'd29;
            5:       setting = 5'd16;
            default: setting = 5'($urandom_range(0, 31));
         endcase
         write_iterations(setting);
         for (int k = 0; k < 150; k++) begin
            // new idle pattern every 25 requests, one in four with none at all
            if (k % 25 == 0) begin
               mode = 2'($urandom_range(0, 3));
               req_idle_en = mode[0];
               rsp_idle_en = mode[1];
            end
            send_angle(pick_angle());
         end
         drain_responses();
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   initial begin
      req_if.valid <= 1'b0;
      req_if.angle <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_angle_extremes();
      test_iteration_limits();
      test_random_sweep();

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sincos_expected.size() != 0)
         report_mismatch("missing responses", 32'd0, iterations_shadow, 32'd0,
                         sincos_expected.size());

      $display("Sent %0d angles over %0d iteration-count writes, %0d responses scored",
               angles_sent, settings_used, responses_checked);
      $display("Covered wrap and fold edges, zero and saturated counts, random gaps");
      if (error_count == 0) begin
         $display("cordic_sine_cosine_top verification clean");
      end else begin
         $display("cordic_sine_cosine_top verification failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/csc_pkg.sv
src/csc_channels.sv
src/csc_prep.sv
src/csc_stage.sv
src/cordic_sine_cosine_top.sv
bench/tb_cordic_sine_cosine_top.sv
